// File: rtl/sld_pkg.sv
// shared types and constants for the sync/length deframer
package sld_pkg;

    localparam logic [7:0]  SYNC_FIRST       = 8'h94;
    localparam logic [7:0]  SYNC_SECOND      = 8'hC3;
    localparam logic [15:0] MAX_LENGTH_RESET = 16'd512;

    // header window depth: two sync bytes and two length bytes
    localparam int WIN_DEPTH = 4;

    // scan step actions
    localparam logic [1:0] ACT_HOLD  = 2'd0;
    localparam logic [1:0] ACT_SHIFT = 2'd1;
    localparam logic [1:0] ACT_FRAME = 2'd2;

    typedef logic [WIN_DEPTH-1:0][7:0] win_t;
    typedef logic [2:0]                win_cnt_t;

    typedef struct packed {
        logic [1:0]  action;
        logic [15:0] len;
    } scan_res_t;

endpackage

// File: rtl/sld_scan.sv
// one step of the header scan: sync compare, length compare, drop decision
module sld_scan
    import sld_pkg::*;
(
    input  win_t      win,
    input  win_cnt_t  cnt,
    input  logic [15:0] max_length,
    output scan_res_t res
);

    logic        sync_ok;
    logic [15:0] len;

    assign sync_ok = (win[0] == SYNC_FIRST) && (win[1] == SYNC_SECOND);
    assign len     = {win[2], win[3]};

    // decide what to do with the held bytes this cycle
    always_comb
    begin
        res.len    = len;
        res.action = ACT_HOLD;
        if ((cnt >= 3'd2) && !sync_ok)
        begin
            res.action = ACT_SHIFT;
        end
        else if (cnt == 3'(WIN_DEPTH))
        begin
            if (len > max_length)
                res.action = ACT_SHIFT;
            else
                res.action = ACT_FRAME;
        end
    end

endmodule

// File: rtl/sync_length_frame_deframer.sv
// sync word / length prefix deframer top level
//
//  channel  | direction | handshake         | payload
//  ---------+-----------+-------------------+----------------------------------------
//  in       | input     | in_valid/in_stall | in_byte
//  out      | output    | out_valid/out_stall | out_byte, is_last, empty_frame, frame_length
//  cfg      | input     | cfg_we            | cfg_data (max_length)
//
// a payload word shows on the output the cycle after it is taken, one word per
// cycle while out_stall is low. a header word takes one load step plus one scan
// step per dropped byte and one for the final decision, each made by the single scan unit.
// reset sets the window count to zero, goes back to hunting and sets max_length to 512.
// a result waiting under out_stall holds in_stall high and pauses the scan
// until the output register is taken.
module sync_length_frame_deframer
    import sld_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  in_byte,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  out_byte,
    output logic        is_last,
    output logic        empty_frame,
    output logic [15:0] frame_length,
    input  logic        cfg_we,
    input  logic [15:0] cfg_data
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_SCAN = 1'b1;

    logic        state_reg, state_next;
    win_t        win_reg, win_next;
    win_cnt_t    cnt_reg, cnt_next;
    logic        in_payload_reg, in_payload_next;
    logic [15:0] bytes_left_reg, bytes_left_next;
    logic [15:0] cur_len_reg, cur_len_next;
    logic [15:0] max_length_reg;

    logic        out_valid_reg, out_valid_next;
    logic [7:0]  out_byte_reg, out_byte_next;
    logic        is_last_reg, is_last_next;
    logic        empty_reg, empty_next;
    logic [15:0] flen_reg, flen_next;

    logic        out_free;
    logic        in_acc;
    scan_res_t   scan_res;

    assign out_free = !out_valid_reg || !out_stall;
    assign in_stall = (state_reg != ST_IDLE) || !out_free;
    assign in_acc   = in_valid && !in_stall;

    sld_scan u_scan (
        .win        (win_reg),
        .cnt        (cnt_reg),
        .max_length (max_length_reg),
        .res        (scan_res)
    );

    // sequencer and datapath
    always_comb
    begin
        state_next      = state_reg;
        win_next        = win_reg;
        cnt_next        = cnt_reg;
        in_payload_next = in_payload_reg;
        bytes_left_next = bytes_left_reg;
        cur_len_next    = cur_len_reg;
        out_valid_next  = out_valid_reg && out_stall;
        out_byte_next   = out_byte_reg;
        is_last_next    = is_last_reg;
        empty_next      = empty_reg;
        flen_next       = flen_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    if (in_payload_reg)
                    begin
                        // pass the payload word straight through
                        bytes_left_next = bytes_left_reg - 16'd1;
                        out_valid_next  = 1'b1;
                        out_byte_next   = in_byte;
                        is_last_next    = (bytes_left_reg == 16'd1);
                        empty_next      = 1'b0;
                        flen_next       = cur_len_reg;
                        if (bytes_left_reg == 16'd1)
                        begin
                            in_payload_next = 1'b0;
                            cnt_next        = '0;
                        end
                    end
                    else
                    begin
                        // append the word to the held header bytes
                        win_next[cnt_reg[1:0]] = in_byte;
                        cnt_next               = cnt_reg + 3'd1;
                        state_next             = ST_SCAN;
                    end
                end
            end
            ST_SCAN:
            begin
                if (out_free)
                begin
                    unique case (scan_res.action)
                        ACT_SHIFT:
                        begin
                            win_next = win_reg >> 8;
                            cnt_next = cnt_reg - 3'd1;
                        end
                        ACT_FRAME:
                        begin
                            cnt_next     = '0;
                            cur_len_next = scan_res.len;
                            state_next   = ST_IDLE;
                            if (scan_res.len == 16'd0)
                            begin
                                out_valid_next = 1'b1;
                                out_byte_next  = 8'd0;
                                is_last_next   = 1'b1;
                                empty_next     = 1'b1;
                                flen_next      = 16'd0;
                            end
                            else
                            begin
                                in_payload_next = 1'b1;
                                bytes_left_next = scan_res.len;
                            end
                        end
                        ACT_HOLD:
                        begin
                            state_next = ST_IDLE;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            cnt_reg        <= '0;
            in_payload_reg <= 1'b0;
            bytes_left_reg <= '0;
            cur_len_reg    <= '0;
            out_valid_reg  <= 1'b0;
            max_length_reg <= MAX_LENGTH_RESET;
        end
        else
        begin
            state_reg      <= state_next;
            cnt_reg        <= cnt_next;
            in_payload_reg <= in_payload_next;
            bytes_left_reg <= bytes_left_next;
            cur_len_reg    <= cur_len_next;
            out_valid_reg  <= out_valid_next;
            if (cfg_we)
                max_length_reg <= cfg_data;
        end
    end

    // window and result payload
    always_ff @(posedge clk)
    begin
        win_reg      <= win_next;
        out_byte_reg <= out_byte_next;
        is_last_reg  <= is_last_next;
        empty_reg    <= empty_next;
        flen_reg     <= flen_next;
    end

    assign out_valid    = out_valid_reg;
    assign out_byte     = out_byte_reg;
    assign is_last      = is_last_reg;
    assign empty_frame  = empty_reg;
    assign frame_length = flen_reg;

    // window never overfills
    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= 3'(WIN_DEPTH))
        else $error("header window count out of range");

    // payload phase always has words left
    a_payload_left: assert property (@(posedge clk) disable iff (!rst_n)
        in_payload_reg |-> (bytes_left_reg != 16'd0))
        else $error("payload phase with no words left");

    // no scan while passing payload
    a_scan_hunting: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) |-> !in_payload_reg)
        else $error("scan running during payload phase");

    // empty frame result is self consistent
    a_empty_result: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && empty_reg) |-> (is_last_reg && flen_reg == 16'd0))
        else $error("empty frame result malformed");

    // a header word always starts a scan
    a_load_scan: assert property (@(posedge clk) disable iff (!rst_n)
        (in_acc && !in_payload_reg) |=> (state_reg == ST_SCAN))
        else $error("header word did not start a scan");

endmodule
